>>> hdl/hbkd_pkg.sv
// Package for the HID boot keyboard report decoder.
// Holds the ring sizing, key codes, controller command struct and the US key map.
// No dependencies.
`default_nettype none

package hbkd_pkg;

    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int NUM_SLOTS  = 6;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
    localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
    localparam logic [7:0] MOD_ALT_MASK   = 8'h44;

    localparam logic [7:0] KEY_NONE      = 8'h00;
    localparam logic [7:0] KEY_ROLLOVER  = 8'h01;
    localparam logic [7:0] KEY_CAPS_LOCK = 8'h39;

    typedef logic [RING_AW-1:0] ring_ptr_t;
    typedef logic [7:0]         key_code_t;
    typedef logic [6:0]         char_t;

    typedef struct packed {
        logic              load;
        logic              slot_en;
        logic [SLOT_W-1:0] slot_idx;
        logic              finish;
    } hbkd_cmd_t;

    function automatic ring_ptr_t ptr_inc(input ring_ptr_t p);
        ring_ptr_t r;
        if (p == RING_AW'(RING_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    function automatic char_t map_code(input logic [6:0] code, input logic shifted);
        char_t c;
        c = 7'h00;
        if (code >= 7'h04 && code <= 7'h1D) begin
            c = (shifted ? 7'h41 : 7'h61) + (code - 7'h04);
        end
        else begin
            case (code)
                7'h1E: c = shifted ? 7'h21 : 7'h31;
                7'h1F: c = shifted ? 7'h40 : 7'h32;
                7'h20: c = shifted ? 7'h23 : 7'h33;
                7'h21: c = shifted ? 7'h24 : 7'h34;
                7'h22: c = shifted ? 7'h25 : 7'h35;
                7'h23: c = shifted ? 7'h5E : 7'h36;
                7'h24: c = shifted ? 7'h26 : 7'h37;
                7'h25: c = shifted ? 7'h2A : 7'h38;
                7'h26: c = shifted ? 7'h28 : 7'h39;
                7'h27: c = shifted ? 7'h29 : 7'h30;
                7'h28: c = 7'h0A;
                7'h29: c = 7'h1B;
                7'h2A: c = 7'h08;
                7'h2B: c = 7'h09;
                7'h2C: c = 7'h20;
                7'h2D: c = shifted ? 7'h5F : 7'h2D;
                7'h2E: c = shifted ? 7'h2B : 7'h3D;
                7'h2F: c = shifted ? 7'h7B : 7'h5B;
                7'h30: c = shifted ? 7'h7D : 7'h5D;
                7'h31: c = shifted ? 7'h7C : 7'h5C;
                7'h33: c = shifted ? 7'h3A : 7'h3B;
                7'h34: c = shifted ? 7'h22 : 7'h27;
                7'h35: c = shifted ? 7'h7E : 7'h60;
                7'h36: c = shifted ? 7'h3C : 7'h2C;
                7'h37: c = shifted ? 7'h3E : 7'h2E;
                7'h38: c = shifted ? 7'h3F : 7'h2F;
                7'h54: c = 7'h2F;
                7'h55: c = 7'h2A;
                7'h56: c = 7'h2D;
                7'h57: c = 7'h2B;
                7'h58: c = 7'h0A;
                7'h59: c = 7'h31;
                7'h5A: c = 7'h32;
                7'h5B: c = 7'h33;
                7'h5C: c = 7'h34;
                7'h5D: c = 7'h35;
                7'h5E: c = 7'h36;
                7'h5F: c = 7'h37;
                7'h60: c = 7'h38;
                7'h61: c = 7'h39;
                7'h62: c = 7'h30;
                7'h63: c = 7'h2E;
                default: c = 7'h00;
            endcase
        end
        return c;
    endfunction

    function automatic char_t caps_swap(input char_t c, input logic caps);
        char_t r;
        r = c;
        if (caps) begin
            if (c >= 7'h61 && c <= 7'h7A)
                r = c - 7'h20;
            else if (c >= 7'h41 && c <= 7'h5A)
                r = c + 7'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/hid_boot_keyboard_report_decoder_top.sv
// Top level of the HID boot keyboard report decoder.
// Connects hbkd_ctrl and hbkd_datapath; uses hbkd_pkg.
//
// Channel  Direction  Transaction
// s_axis   in         tuser = command, tdata = modifier byte and six key codes
// m_axis   out        tuser = char_valid, tdata = character and status flags
//
// A report steps through the six key slots, one key slot per cycle, then loads the result
// register once the output register is free; only then is the next item accepted.
// A read skips the key slots; the ring memory read is registered and follows the read pointer.
// Reset clears pointers, flags and key history; ring contents stay undefined, no clearing pass.
// A result waits in the output register under backpressure while the next item is accepted.
`default_nettype none

module hid_boot_keyboard_report_decoder_top
    import hbkd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Bits from 0: modifier_bits, key_code_0 .. key_code_5.
    input  wire logic [55:0] s_axis_tdata,
    // Bits from 0: command.
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Bits from 0: char_code, buffer_not_empty, caps_lock_on, shift_held, ctrl_held,
    // alt_held, zero fill.
    output logic [15:0]      m_axis_tdata,
    // Bits from 0: char_valid.
    output logic             m_axis_tuser
);

    hbkd_cmd_t cmd;

    hbkd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    hbkd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_data        (s_axis_tdata),
        .in_command     (s_axis_tuser),
        .out_data       (m_axis_tdata),
        .out_char_valid (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> hdl/hbkd_ctrl.sv
// Controller for the HID boot keyboard report decoder.
// Sequences accept, the six key slots and the result hand-off; uses hbkd_pkg.
`default_nettype none

module hbkd_ctrl
    import hbkd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_axis_tvalid,
    output logic           s_axis_tready,
    input  wire logic      s_axis_tuser,
    output logic           m_axis_tvalid,
    input  wire logic      m_axis_tready,
    output hbkd_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SLOT = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              m_valid_reg, m_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.slot_idx  = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    slot_next  = '0;
                    state_next = (s_axis_tuser == CMD_READ) ? ST_DONE : ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                cmd.slot_en = 1'b1;
                if (slot_reg == SLOT_LAST)
                    state_next = ST_DONE;
                else
                    slot_next = slot_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.slot_en, cmd.finish}))
        else $error("Controller issued more than one command in a cycle.");

    a_last_slot_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.slot_en && cmd.slot_idx == SLOT_LAST) |=> (state_reg == ST_DONE))
        else $error("Controller did not finish after the last key slot.");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_valid_reg)
        else $error("Finished result was not presented.");

endmodule

`default_nettype wire

>>> hdl/hbkd_datapath.sv
// Datapath for the HID boot keyboard report decoder.
// Holds key history, modifier and caps lock flags, the character ring and the result register.
// Uses hbkd_pkg; driven by commands from hbkd_ctrl.
`default_nettype none

module hbkd_datapath
    import hbkd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire hbkd_cmd_t   cmd,
    input  wire logic [55:0] in_data,
    input  wire logic        in_command,
    output logic [15:0]      out_data,
    output logic             out_char_valid
);

    key_code_t keys_reg      [NUM_SLOTS];
    key_code_t prev_keys_reg [NUM_SLOTS];
    char_t     ring_mem_reg  [RING_DEPTH];

    logic      is_read_reg;
    logic      caps_reg, caps_next;
    logic [2:0] mods_reg, mods_next;
    ring_ptr_t rd_ptr_reg, rd_ptr_next;
    ring_ptr_t wr_ptr_reg, wr_ptr_next;
    char_t     rd_data_reg;
    logic [15:0] out_data_reg;
    logic      out_valid_reg;

    key_code_t key;
    logic      seen;
    logic      is_new;
    char_t     ch;
    logic      char_ok;
    ring_ptr_t wr_inc;
    logic      push;
    logic      pop;
    logic      not_empty_after;

    always_comb
    begin
        key  = keys_reg[cmd.slot_idx];
        seen = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            if (prev_keys_reg[j] == key)
                seen = 1'b1;
        end
        is_new  = (key != KEY_NONE) && (key != KEY_ROLLOVER) && !seen;
        ch      = caps_swap(map_code(key[6:0], mods_reg[0]), caps_reg);
        char_ok = is_new && (key != KEY_CAPS_LOCK) && !key[7] && (ch != 7'h00);
        wr_inc  = ptr_inc(wr_ptr_reg);
        push    = cmd.slot_en && char_ok && (wr_inc != rd_ptr_reg);
        pop     = is_read_reg && (rd_ptr_reg != wr_ptr_reg);
    end

    always_comb
    begin
        caps_next   = caps_reg;
        mods_next   = mods_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (cmd.load && in_command == CMD_REPORT)
        begin
            mods_next = {|(in_data[7:0] & MOD_ALT_MASK),
                         |(in_data[7:0] & MOD_CTRL_MASK),
                         |(in_data[7:0] & MOD_SHIFT_MASK)};
        end
        if (cmd.slot_en && is_new && key == KEY_CAPS_LOCK)
            caps_next = ~caps_reg;
        if (push)
            wr_ptr_next = wr_inc;
        if (cmd.finish && pop)
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        not_empty_after = (rd_ptr_next != wr_ptr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_reg   <= 1'b0;
            mods_reg   <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                prev_keys_reg[i] <= '0;
        end
        else
        begin
            caps_reg   <= caps_next;
            mods_reg   <= mods_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            if (cmd.finish && !is_read_reg)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    prev_keys_reg[i] <= keys_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_read_reg <= in_command;
            for (int i = 0; i < NUM_SLOTS; i++)
                keys_reg[i] <= in_data[8*i+8 +: 8];
        end
        if (push)
            ring_mem_reg[wr_ptr_reg] <= ch;
        rd_data_reg <= ring_mem_reg[rd_ptr_reg];
        if (cmd.finish)
        begin
            out_data_reg  <= {4'b0000, mods_reg[2], mods_reg[1], mods_reg[0], caps_reg,
                              not_empty_after, (pop ? rd_data_reg : 7'h00)};
            out_valid_reg <= pop;
        end
    end

    assign out_data       = out_data_reg;
    assign out_char_valid = out_valid_reg;

    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (wr_ptr_reg != rd_ptr_reg))
        else $error("Ring looks empty right after a character was stored.");

    a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && pop) |=> (rd_ptr_reg == ptr_inc($past(rd_ptr_reg))))
        else $error("Read pointer did not advance after a pop.");

endmodule

`default_nettype wire

>>> sim/tb_hid_boot_keyboard_report_decoder_top.sv
// Testbench for hid_boot_keyboard_report_decoder_top: a table of directed reports and reads,
// then random typing, burst and drain phases checked against a keyboard predictor.
// Depends on hbkd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb_hid_boot_keyboard_report_decoder_top;
    import hbkd_pkg::*;

    typedef struct packed {
        logic       char_valid;
        logic [3:0] fill;
        logic       alt_held;
        logic       ctrl_held;
        logic       shift_held;
        logic       caps_lock_on;
        logic       buffer_not_empty;
        logic [6:0] char_code;
    } status_word_t;

    typedef struct packed {
        logic         cmd;
        logic [55:0]  data;
        logic         typed;
        status_word_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Bits from 0: modifier_bits, key_code_0 .. key_code_5.
    logic [55:0] s_axis_tdata = '0;
    // Bits from 0: command.
    logic        s_axis_tuser = CMD_REPORT;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // Bits from 0: char_code, buffer_not_empty, caps_lock_on, shift_held, ctrl_held,
    // alt_held, zero fill.
    logic [15:0] m_axis_tdata;
    // Bits from 0: char_valid.
    logic        m_axis_tuser;

    logic [7:0]   held_keys [6];
    logic         caps_state = 1'b0;
    logic         shift_now = 1'b0;
    logic         ctrl_now = 1'b0;
    logic         alt_now = 1'b0;
    logic [6:0]   typed_chars [$];
    status_word_t awaited_outputs [$];
    stim_row_t    stim_table [$];

    string digit_plain = "1234567890";
    string digit_shift = "!@#$%^&*()";
    string punct_plain = "-=[]\\?;'`,./";
    string punct_shift = "_+{}|?:\"~<>?";
    string keypad_chars = "/*-+\n1234567890.";

    logic steady_flow = 1'b0;
    int   ready_left = 0;
    int   mismatches = 0;
    int   outputs_checked = 0;
    int   items_sent = 0;
    int   reads_sent = 0;
    int   chars_popped = 0;
    int   dropped_chars = 0;
    int   caps_toggles = 0;

    status_word_t seen_out;
    status_word_t want_out;

    hid_boot_keyboard_report_decoder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still awaited", awaited_outputs.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [6:0] usage_to_ascii(input logic [6:0] code, input logic shifted);
        logic [6:0] ch;
        ch = 7'h00;
        if (code >= 7'h04 && code <= 7'h1D)
            ch = (shifted ? 7'h41 : 7'h61) + (code - 7'h04);
        else if (code >= 7'h1E && code <= 7'h27)
            ch = 7'(shifted ? digit_shift[code - 7'h1E] : digit_plain[code - 7'h1E]);
        else if (code == 7'h28)
            ch = 7'h0A;
        else if (code == 7'h29)
            ch = 7'h1B;
        else if (code == 7'h2A)
            ch = 7'h08;
        else if (code == 7'h2B)
            ch = 7'h09;
        else if (code == 7'h2C)
            ch = 7'h20;
        else if (code >= 7'h2D && code <= 7'h38 && code != 7'h32)
            ch = 7'(shifted ? punct_shift[code - 7'h2D] : punct_plain[code - 7'h2D]);
        else if (code >= 7'h54 && code <= 7'h63)
            ch = 7'(keypad_chars[code - 7'h54]);
        return ch;
    endfunction

    // Updates the keyboard state for one transaction and returns the status word it produces.
    function automatic status_word_t decode_item(input logic cmd, input logic [55:0] data);
        status_word_t r;
        logic [7:0]   keys [6];
        logic [7:0]   code;
        logic [6:0]   ch;
        logic         seen;
        r = '0;
        if (cmd == CMD_READ) begin
            reads_sent++;
            if (typed_chars.size() != 0) begin
                r.char_code = typed_chars.pop_front();
                r.char_valid = 1'b1;
                chars_popped++;
            end
        end
        else begin
            shift_now = |(data[7:0] & MOD_SHIFT_MASK);
            ctrl_now = |(data[7:0] & MOD_CTRL_MASK);
            alt_now = |(data[7:0] & MOD_ALT_MASK);
            for (int i = 0; i < 6; i++)
                keys[i] = data[8 * i + 8 +: 8];
            for (int i = 0; i < 6; i++) begin
                code = keys[i];
                if (code != KEY_NONE && code != KEY_ROLLOVER) begin
                    seen = 1'b0;
                    for (int j = 0; j < 6; j++)
                        if (held_keys[j] == code)
                            seen = 1'b1;
                    if (!seen && code == KEY_CAPS_LOCK) begin
                        caps_state = ~caps_state;
                        caps_toggles++;
                    end
                    else if (!seen && !code[7]) begin
                        ch = usage_to_ascii(code[6:0], shift_now);
                        if (caps_state && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")))
                            ch = ch ^ 7'h20;
                        if (ch != 7'h00) begin
                            if (typed_chars.size() < RING_DEPTH - 1)
                                typed_chars.push_back(ch);
                            else
                                dropped_chars++;
                        end
                    end
                end
            end
            for (int i = 0; i < 6; i++)
                held_keys[i] = keys[i];
        end
        r.buffer_not_empty = (typed_chars.size() != 0);
        r.caps_lock_on = caps_state;
        r.shift_held = shift_now;
        r.ctrl_held = ctrl_now;
        r.alt_held = alt_now;
        return r;
    endfunction

    function automatic logic [7:0] random_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 8'($urandom_range(8'h04, 8'h38));
        else if (roll < 55)
            return 8'($urandom_range(8'h54, 8'h63));
        else if (roll < 60)
            return KEY_CAPS_LOCK;
        else if (roll < 80)
            return KEY_NONE;
        else if (roll < 83)
            return KEY_ROLLOVER;
        else if (roll < 90)
            return held_keys[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] random_mods();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 8'h00;
        else if (roll < 80)
            return 8'h01 << $urandom_range(0, 6);
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic cmd, input logic [55:0] data, input logic typed,
                             input status_word_t want);
        int           gap;
        status_word_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = decode_item(cmd, data);
        awaited_outputs.push_back(typed ? want : predicted);
        items_sent++;
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic wait_for_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_outputs.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        int gap;
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end
        else begin
            gap = steady_flow ? 0 : pick_gap();
            if (gap == 0) begin
                m_axis_tready <= 1'b1;
                ready_left <= $urandom_range(0, 5);
            end
            else begin
                m_axis_tready <= 1'b0;
                ready_left <= gap - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_out = {m_axis_tuser, m_axis_tdata};
            if (awaited_outputs.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result tdata=%h tuser=%b", $realtime,
                             m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else begin
                want_out = awaited_outputs.pop_front();
                outputs_checked++;
                if (seen_out !== want_out) begin
                    if (mismatches < 10)
                        $display({"%0t: result %0d mismatch: char %h/%h valid %b/%b ",
                                  "nonempty %b/%b caps %b/%b shift %b/%b ctrl %b/%b ",
                                  "alt %b/%b fill %h/%h (expected/actual)"},
                                 $realtime, outputs_checked,
                                 want_out.char_code, seen_out.char_code,
                                 want_out.char_valid, seen_out.char_valid,
                                 want_out.buffer_not_empty, seen_out.buffer_not_empty,
                                 want_out.caps_lock_on, seen_out.caps_lock_on,
                                 want_out.shift_held, seen_out.shift_held,
                                 want_out.ctrl_held, seen_out.ctrl_held,
                                 want_out.alt_held, seen_out.alt_held,
                                 want_out.fill, seen_out.fill);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int         phase_no;
        int         phase_kind;
        int         phase_len;
        int         read_pct;
        int         drain_cycles;
        logic [7:0] mods;
        logic [7:0] keys [6];
        for (int i = 0; i < 6; i++)
            held_keys[i] = KEY_NONE;

        // The first read and the modifier-only reports have fixed answers; the rest go through the predictor.
        stim_table.push_back({CMD_READ, 56'h0, 1'b1, 17'h00000});
        stim_table.push_back({CMD_REPORT, 56'h0000_0000_0000_FF, 1'b1, 17'h00E00});
        stim_table.push_back({CMD_REPORT, 56'h0000_0000_0000_44, 1'b1, 17'h00800});
        stim_table.push_back({CMD_REPORT, 56'h0000_0000_0000_11, 1'b1, 17'h00400});
        stim_table.push_back({CMD_REPORT, 56'h0000_0000_0000_22, 1'b1, 17'h00200});
        stim_table.push_back({CMD_REPORT, 56'h0000_0000_0000_80, 1'b1, 17'h00000});
        stim_table.push_back({CMD_REPORT, 56'h0032_FF01_0439_00, 1'b0, 17'h0});
        stim_table.push_back({CMD_REPORT, 56'h001D_6354_0505_20, 1'b0, 17'h0});
        stim_table.push_back({CMD_REPORT, 56'h0000_0000_0000_00, 1'b0, 17'h0});
        stim_table.push_back({CMD_REPORT, 56'h28_2D38_2739_3902, 1'b0, 17'h0});
        stim_table.push_back({CMD_READ, 56'hFF_FFFF_FFFF_FFFF, 1'b0, 17'h0});
        stim_table.push_back({CMD_REPORT, 56'hFF_FFFF_FFFF_FFFF, 1'b0, 17'h0});
        stim_table.push_back({CMD_REPORT, 56'h0203_5364_807F_00, 1'b0, 17'h0});
        stim_table.push_back({CMD_READ, 56'h0, 1'b0, 17'h0});
        for (int i = 0; i < 10; i++)
            stim_table.push_back({CMD_REPORT, (i % 2 == 0) ? 56'h0908_0706_0504_00
                                                           : 56'h0F0E_0D0C_0B0A_00,
                                  1'b0, 17'h0});
        stim_table.push_back({CMD_READ, 56'h0, 1'b0, 17'h0});

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[n])
            send_item(stim_table[n].cmd, stim_table[n].data, stim_table[n].typed,
                      stim_table[n].want);

        phase_no = 0;
        while (items_sent < 1050) begin
            phase_kind = $urandom_range(0, 9);
            phase_len = $urandom_range(10, 60);
            steady_flow = ($urandom_range(0, 4) == 0);
            read_pct = (phase_kind < 6) ? 35 : ((phase_kind < 8) ? 5 : 85);
            for (int k = 0; k < phase_len && items_sent < 1050; k++) begin
                if ($urandom_range(0, 99) < read_pct) begin
                    send_item(CMD_READ, {24'($urandom), 32'($urandom)}, 1'b0, '0);
                end
                else begin
                    mods = random_mods();
                    for (int i = 0; i < 6; i++)
                        keys[i] = ($urandom_range(0, 99) < 15) ? KEY_NONE : random_key();
                    send_item(CMD_REPORT, {keys[5], keys[4], keys[3], keys[2], keys[1],
                                           keys[0], mods}, 1'b0, '0);
                end
            end
            phase_no++;
            if (phase_no % 5 == 2)
                wait_for_outputs();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        drain_cycles = 0;
        while (awaited_outputs.size() != 0 && drain_cycles < 20000) begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20)
            @(posedge clk);
        if (awaited_outputs.size() != 0) begin
            $display("%0d expected results never arrived", awaited_outputs.size());
            mismatches += awaited_outputs.size();
        end

        $display("Sent %0d transactions (%0d reads), checked %0d results, %0d mismatches.",
                 items_sent, reads_sent, outputs_checked, mismatches);
        $display("Characters read back: %0d, dropped on a full ring: %0d, caps toggles: %0d.",
                 chars_popped, dropped_chars, caps_toggles);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
